// File: src/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, suspended while rst_n is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Concurrent check on clk, also active during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/howd_pkg.sv
// Types and constants of the heartbeat owner watchdog.
package howd_pkg;

    localparam int ID_W   = 22;
    localparam int CFG_W  = 16;
    localparam int MODE_W = 3;
    localparam int STAT_W = 3;

    localparam logic [MODE_W-1:0] MODE_TICK       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REGISTER   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DEREGISTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_HEARTBEAT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_GATED      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXISTS = 3'd1;
    localparam logic [STAT_W-1:0] ST_INVAL  = 3'd2;
    localparam logic [STAT_W-1:0] ST_PERM   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE   = 3'd4;

    typedef enum logic [1:0] {
        CFG_TIMEOUT_ABSENT   = 2'd0,
        CFG_TIMEOUT_PRESENT  = 2'd1,
        CFG_TIMEOUT_SHUTDOWN = 2'd2,
        CFG_STORE_READY      = 2'd3
    } cfg_index_t;

    localparam logic [CFG_W-1:0] TIMEOUT_ABSENT_RST   = 16'd10;
    localparam logic [CFG_W-1:0] TIMEOUT_PRESENT_RST  = 16'd10;
    localparam logic [CFG_W-1:0] TIMEOUT_SHUTDOWN_RST = 16'd120;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   requester_id;
        logic              shutdown_flag;
    } cmd_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              handled;
        logic              kill_request;
        logic [ID_W-1:0]   kill_id;
        logic              start_request;
    } result_t;

endpackage

// File: src/heartbeat_owner_watchdog_core.sv
// Heartbeat owner watchdog: top level with command and result pipeline.
//
//  channel | dir | handshake              | beat
//  --------+-----+------------------------+----------------------------------
//  in      | in  | in_valid / in_stall    | cmd_t: mode, requester_id, flag
//  out     | out | out_valid / out_stall  | result_t: status .. start_request
//  cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One beat in, one beat out; a new command is taken every cycle unless an output stall backs up into it.
// A beat taken into the input register is decoded and lands in the result
// register when the result register advances. Reset clears phase, owner,
// tick count and loads the default timeouts. An output stall holds the
// result register and, once the input register is full, stalls the input
// side; cfg_ready is always high.
`include "assert_macros.svh"

module heartbeat_owner_watchdog_core #(
    parameter int TICK_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  howd_pkg::cmd_t                in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output howd_pkg::result_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  howd_pkg::cfg_index_t          cfg_index,
    input  logic [howd_pkg::CFG_W-1:0]    cfg_data
);
    import howd_pkg::*;

    localparam int CMP_W = (TICK_BITS > CFG_W) ? TICK_BITS : CFG_W;

    typedef enum logic [1:0] {
        PH_ABSENT   = 2'd0,
        PH_PRESENT  = 2'd1,
        PH_SHUTDOWN = 2'd2
    } phase_t;

    logic [CFG_W-1:0]     t_absent_reg;
    logic [CFG_W-1:0]     t_present_reg;
    logic [CFG_W-1:0]     t_shutdown_reg;
    logic                 store_ready_reg;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [ID_W-1:0]      owner_reg;
    logic [ID_W-1:0]      owner_next;
    logic [TICK_BITS-1:0] elapsed_reg;
    logic [TICK_BITS-1:0] elapsed_next;
    logic [TICK_BITS-1:0] elapsed_inc;
    logic [CFG_W-1:0]     limit;
    logic                 timed_out;

    logic                 s1_valid_reg;
    cmd_t                 s1_data_reg;
    logic                 s1_advance;
    logic                 s1_fire;

    logic                 out_valid_reg;
    result_t              out_data_reg;
    result_t              res_next;

    assign cfg_ready  = 1'b1;
    assign s1_advance = !out_valid_reg || !out_stall;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_absent_reg    <= TIMEOUT_ABSENT_RST;
            t_present_reg   <= TIMEOUT_PRESENT_RST;
            t_shutdown_reg  <= TIMEOUT_SHUTDOWN_RST;
            store_ready_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TIMEOUT_ABSENT:   t_absent_reg    <= cfg_data;
                CFG_TIMEOUT_PRESENT:  t_present_reg   <= cfg_data;
                CFG_TIMEOUT_SHUTDOWN: t_shutdown_reg  <= cfg_data;
                CFG_STORE_READY:      store_ready_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        elapsed_inc = (elapsed_reg == {TICK_BITS{1'b1}}) ? elapsed_reg
                                                         : elapsed_reg + 1'b1;
        unique case (phase_reg)
            PH_ABSENT:  limit = t_absent_reg;
            PH_PRESENT: limit = t_present_reg;
            default:    limit = t_shutdown_reg;
        endcase
        timed_out = CMP_W'(elapsed_inc) > CMP_W'(limit);
    end

    always_comb
    begin
        phase_next             = phase_reg;
        owner_next             = owner_reg;
        elapsed_next           = elapsed_reg;
        res_next.status        = ST_NONE;
        res_next.handled       = 1'b0;
        res_next.kill_request  = 1'b0;
        res_next.kill_id       = '0;
        res_next.start_request = 1'b0;

        unique case (s1_data_reg.mode)
            MODE_TICK:
            begin
                elapsed_next = elapsed_inc;
                if (timed_out && store_ready_reg)
                begin
                    if (phase_reg == PH_ABSENT)
                    begin
                        elapsed_next           = '0;
                        res_next.start_request = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_ABSENT;
                    end
                end
            end
            MODE_REGISTER:
            begin
                res_next.handled = 1'b1;
                if (phase_reg != PH_ABSENT)
                begin
                    res_next.status = ST_EXISTS;
                end
                else
                begin
                    owner_next      = s1_data_reg.requester_id;
                    phase_next      = PH_PRESENT;
                    elapsed_next    = '0;
                    res_next.status = ST_OK;
                end
            end
            MODE_DEREGISTER:
            begin
                res_next.handled = 1'b1;
                res_next.status  = ST_OK;
                if (s1_data_reg.shutdown_flag)
                begin
                    if (phase_reg == PH_PRESENT)
                    begin
                        res_next.kill_request = 1'b1;
                        res_next.kill_id      = owner_reg;
                        phase_next            = PH_SHUTDOWN;
                    end
                    else
                    begin
                        phase_next = PH_ABSENT;
                    end
                    owner_next = '0;
                end
            end
            MODE_HEARTBEAT:
            begin
                res_next.handled = 1'b1;
                if (phase_reg != PH_PRESENT || s1_data_reg.requester_id != owner_reg)
                begin
                    res_next.status = ST_INVAL;
                end
                else
                begin
                    elapsed_next    = '0;
                    res_next.status = ST_OK;
                end
            end
            MODE_GATED:
            begin
                if (phase_reg == PH_PRESENT && s1_data_reg.requester_id != owner_reg)
                begin
                    res_next.handled = 1'b1;
                    res_next.status  = ST_PERM;
                end
            end
            default: ;
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            s1_data_reg <= in_data;
        end
    end

    // supervisor state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ABSENT;
            owner_reg     <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                phase_reg   <= phase_next;
                owner_reg   <= owner_next;
                elapsed_reg <= elapsed_next;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_data_reg <= res_next;
        end
    end

    `ASSERT_CLK(a_kill_is_ok, out_valid && out_data.kill_request |-> out_data.status == ST_OK && out_data.handled, "kill beat without ok status")
    `ASSERT_CLK(a_start_unhandled, out_valid && out_data.start_request |-> out_data.status == ST_NONE && !out_data.handled && !out_data.kill_request, "start beat carries command status")
    `ASSERT_CLK(a_kill_enters_shutdown, s1_fire && res_next.kill_request |=> phase_reg == PH_SHUTDOWN && owner_reg == '0, "kill did not enter shutdown")

endmodule

// File: dv/heartbeat_owner_watchdog_core_tb.sv
// Self-checking testbench for the heartbeat owner watchdog core.
`timescale 1ns / 100ps

module heartbeat_owner_watchdog_core_tb;
    import howd_pkg::*;

    localparam int TICK_BITS = 16;
    localparam logic [MODE_W-1:0] MODE_OTHER  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE7 = 3'd7;
    localparam logic [ID_W-1:0] ID_ALL_ONES = '1;

    typedef enum logic [1:0] {
        PH_ABSENT   = 2'd0,
        PH_PRESENT  = 2'd1,
        PH_SHUTDOWN = 2'd2
    } wd_phase_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    cmd_t           in_data = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    result_t        out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    cfg_index_t     cfg_index = CFG_TIMEOUT_ABSENT;
    logic [CFG_W-1:0] cfg_data = '0;

    cmd_t           cmd_backlog[$];
    result_t        pending_results[$];
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    bit             hold_send = 1'b0;
    int             mismatch_cnt = 0;
    logic [ID_W-1:0] gen_owner = '0;

    // predicted watchdog state and settings
    wd_phase_t              wd_phase = PH_ABSENT;
    logic [ID_W-1:0]        wd_owner = '0;
    logic [TICK_BITS-1:0]   wd_elapsed = '0;
    logic [CFG_W-1:0]       tmo_absent = TIMEOUT_ABSENT_RST;
    logic [CFG_W-1:0]       tmo_present = TIMEOUT_PRESENT_RST;
    logic [CFG_W-1:0]       tmo_shutdown = TIMEOUT_SHUTDOWN_RST;
    logic                   store_rdy = 1'b0;

    heartbeat_owner_watchdog_core #(
        .TICK_BITS(TICK_BITS)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t predict_result(cmd_t c);
        result_t r;
        logic [CFG_W-1:0] limit;
        r = '0;
        r.status = ST_NONE;
        case (c.mode)
            MODE_TICK:
            begin
                if (wd_elapsed != '1)
                    wd_elapsed = wd_elapsed + 1'b1;
                case (wd_phase)
                    PH_ABSENT:  limit = tmo_absent;
                    PH_PRESENT: limit = tmo_present;
                    default:    limit = tmo_shutdown;
                endcase
                if (wd_elapsed > limit && store_rdy)
                begin
                    if (wd_phase == PH_ABSENT)
                    begin
                        wd_elapsed = '0;
                        r.start_request = 1'b1;
                    end
                    else
                    begin
                        wd_phase = PH_ABSENT;
                    end
                end
            end
            MODE_REGISTER:
            begin
                r.handled = 1'b1;
                if (wd_phase != PH_ABSENT)
                begin
                    r.status = ST_EXISTS;
                end
                else
                begin
                    wd_owner = c.requester_id;
                    wd_phase = PH_PRESENT;
                    wd_elapsed = '0;
                    r.status = ST_OK;
                end
            end
            MODE_DEREGISTER:
            begin
                r.handled = 1'b1;
                r.status = ST_OK;
                if (c.shutdown_flag)
                begin
                    if (wd_phase == PH_PRESENT)
                    begin
                        r.kill_request = 1'b1;
                        r.kill_id = wd_owner;
                        wd_phase = PH_SHUTDOWN;
                    end
                    else
                    begin
                        wd_phase = PH_ABSENT;
                    end
                    wd_owner = '0;
                end
            end
            MODE_HEARTBEAT:
            begin
                r.handled = 1'b1;
                if (wd_phase != PH_PRESENT || c.requester_id != wd_owner)
                begin
                    r.status = ST_INVAL;
                end
                else
                begin
                    wd_elapsed = '0;
                    r.status = ST_OK;
                end
            end
            MODE_GATED:
            begin
                if (wd_phase == PH_PRESENT && c.requester_id != wd_owner)
                begin
                    r.handled = 1'b1;
                    r.status = ST_PERM;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    // driver: a stalled beat is held until taken
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                pending_results.push_back(predict_result(in_data));
            if (!(in_valid && in_stall))
            begin
                if (!hold_send && cmd_backlog.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= cmd_backlog.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"unexpected result beat: status=%0d handled=%0b",
                                  " kill=%0b kill_id=%h start=%0b"},
                                 out_data.status, out_data.handled, out_data.kill_request,
                                 out_data.kill_id, out_data.start_request);
                end
                else if (out_data.status !== pending_results[0].status ||
                         out_data.handled !== pending_results[0].handled ||
                         out_data.kill_request !== pending_results[0].kill_request ||
                         out_data.kill_id !== pending_results[0].kill_id ||
                         out_data.start_request !== pending_results[0].start_request)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"mismatch: exp status=%0d handled=%0b kill=%0b kill_id=%h start=%0b",
                                  " got status=%0d handled=%0b kill=%0b kill_id=%h start=%0b"},
                                 pending_results[0].status, pending_results[0].handled,
                                 pending_results[0].kill_request, pending_results[0].kill_id,
                                 pending_results[0].start_request,
                                 out_data.status, out_data.handled, out_data.kill_request,
                                 out_data.kill_id, out_data.start_request);
                    void'(pending_results.pop_front());
                end
                else
                begin
                    void'(pending_results.pop_front());
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TIMEOUT_ABSENT:   tmo_absent = val;
            CFG_TIMEOUT_PRESENT:  tmo_present = val;
            CFG_TIMEOUT_SHUTDOWN: tmo_shutdown = val;
            default:              store_rdy = val[0];
        endcase
    endtask

    task automatic push_cmd(input logic [MODE_W-1:0] m, input logic [ID_W-1:0] id,
                            input logic flag);
        cmd_t c;
        c.mode = m;
        c.requester_id = id;
        c.shutdown_flag = flag;
        cmd_backlog.push_back(c);
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
            return gen_owner;
        else if (sel < 85)
            return ID_W'($urandom_range(1, 3));
        return ID_W'($urandom);
    endfunction

    // mostly owner life cycles: register, heartbeats amid ticks, deregister
    task automatic push_random_cmds(input int n);
        cmd_t c;
        int pick;
        int k;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            c.requester_id = pick_id();
            c.shutdown_flag = 1'($urandom_range(1));
            if (pick < 40)
            begin
                c.mode = MODE_TICK;
                c.requester_id = ID_W'($urandom);
            end
            else if (pick < 50)
            begin
                c.mode = MODE_REGISTER;
                if ($urandom_range(1))
                    c.requester_id = ID_W'($urandom);
                gen_owner = c.requester_id;
            end
            else if (pick < 68)
            begin
                c.mode = MODE_HEARTBEAT;
            end
            else if (pick < 76)
            begin
                c.mode = MODE_DEREGISTER;
            end
            else if (pick < 88)
            begin
                c.mode = MODE_GATED;
            end
            else if (pick < 94)
            begin
                c.mode = MODE_OTHER;
            end
            else
            begin
                c.mode = MODE_W'($urandom_range(7));
                c.requester_id = ID_W'($urandom);
            end
            cmd_backlog.push_back(c);
        end
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic random_timeouts();
        write_reg(CFG_TIMEOUT_ABSENT, CFG_W'($urandom_range(1, 12)));
        write_reg(CFG_TIMEOUT_PRESENT, CFG_W'($urandom_range(1, 12)));
        write_reg(CFG_TIMEOUT_SHUTDOWN, CFG_W'($urandom_range(1, 12)));
    endtask

    task automatic random_phase(input int n, input bit pause);
        push_random_cmds(n / 2);
        if (pause)
        begin
            do
                @(negedge clk);
            while (cmd_backlog.size() > n / 4);
            hold_send = 1'b1;
            do
                @(negedge clk);
            while (in_valid || pending_results.size() != 0);
            repeat (5) @(negedge clk);
            hold_send = 1'b0;
        end
        push_random_cmds(n - n / 2);
        drain();
    endtask

    initial
    begin
        int k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, timeout actions suppressed
        push_cmd(MODE_TICK, ID_ALL_ONES, 1'b1);
        push_cmd(MODE_REGISTER, ID_ALL_ONES, 1'b0);
        push_cmd(MODE_REGISTER, 22'd5, 1'b0);
        push_cmd(MODE_HEARTBEAT, 22'd5, 1'b0);
        push_cmd(MODE_HEARTBEAT, ID_ALL_ONES, 1'b0);
        push_cmd(MODE_GATED, 22'd5, 1'b0);
        push_cmd(MODE_GATED, ID_ALL_ONES, 1'b1);
        push_cmd(MODE_OTHER, 22'd0, 1'b0);
        push_cmd(MODE_SPARE6, 22'd1, 1'b0);
        push_cmd(MODE_SPARE7, ID_ALL_ONES, 1'b1);
        push_cmd(MODE_DEREGISTER, 22'd7, 1'b0);
        push_cmd(MODE_DEREGISTER, 22'd9, 1'b1);
        push_cmd(MODE_HEARTBEAT, ID_ALL_ONES, 1'b0);
        push_cmd(MODE_GATED, 22'd1, 1'b0);
        push_cmd(MODE_REGISTER, 22'd2, 1'b0);
        push_cmd(MODE_DEREGISTER, 22'd3, 1'b1);
        push_cmd(MODE_HEARTBEAT, 22'd0, 1'b0);
        push_cmd(MODE_DEREGISTER, 22'd3, 1'b1);
        push_cmd(MODE_REGISTER, 22'd0, 1'b0);
        for (k = 0; k < 11; k++)
            push_cmd(MODE_TICK, 22'd0, 1'b0);
        drain();

        // zero timeout in absent, tight timeouts elsewhere
        write_reg(CFG_TIMEOUT_ABSENT, 16'd0);
        write_reg(CFG_TIMEOUT_PRESENT, 16'd1);
        write_reg(CFG_TIMEOUT_SHUTDOWN, 16'd2);
        write_reg(CFG_STORE_READY, 16'd1);
        push_cmd(MODE_DEREGISTER, 22'd4, 1'b1);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_REGISTER, 22'h155555, 1'b0);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_REGISTER, 22'h2aaaaa, 1'b1);
        push_cmd(MODE_HEARTBEAT, 22'h2aaaaa, 1'b0);
        push_cmd(MODE_DEREGISTER, 22'h155555, 1'b1);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        push_cmd(MODE_TICK, 22'd0, 1'b0);
        drain();

        send_idle_pct = 36;
        recv_idle_pct = 68;
        random_timeouts();
        random_phase(320, 1'b1);
        random_timeouts();
        random_phase(320, 1'b0);

        send_idle_pct = 68;
        recv_idle_pct = 36;
        random_timeouts();
        random_phase(320, 1'b0);
        write_reg(CFG_STORE_READY, 16'd0);
        random_timeouts();
        random_phase(320, 1'b1);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(CFG_TIMEOUT_PRESENT, 16'hffff);
        write_reg(CFG_TIMEOUT_SHUTDOWN, 16'hffff);
        write_reg(CFG_TIMEOUT_ABSENT, CFG_W'($urandom_range(1, 12)));
        write_reg(CFG_STORE_READY, 16'd1);
        random_phase(310, 1'b0);
        random_timeouts();
        random_phase(310, 1'b0);

        repeat (10) @(posedge clk);
        if (mismatch_cnt == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
